FILE: hw/rtl/gf4_cyclic_code_codec_macros.svh
// Assertion macros for the GF(4) cyclic code codec.
// Uses the including module's clk and arst_n; no other dependencies.
// Defining SYNTH turns every macro into an empty body.
`ifndef GF4_CYCLIC_CODE_CODEC_MACROS_SVH
`define GF4_CYCLIC_CODE_CODEC_MACROS_SVH

`ifndef SYNTH

// General property, checked on clk while out of reset.
`define GF4CC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication, checked on clk while out of reset.
`define GF4CC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define GF4CC_ASSERT(lbl, prop, msg)

`define GF4CC_ASSERT_IMP(lbl, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/gf4cc_pkg.sv
// Shared constants and helpers for the GF(4) cyclic code codec.
// Holds the generator polynomial, the GF(4) product table and word widths.
// No dependencies.
package gf4cc_pkg;

	// Fixed widths of the word ports and of the symbol count register.
	localparam int WORD_BITS = 40;
	localparam int SYM_CNT_W = 5;
	localparam logic [SYM_CNT_W-1:0] SYM_CNT_RESET = 5'd20;
	localparam int MIN_SYMBOLS = 10;

	// Generator g of degree 9, two bits per symbol, low degree first.
	localparam int GEN_DEGREE = 9;
	localparam int GEN_SYMS = GEN_DEGREE + 1;
	localparam int GEN_W = 2 * GEN_SYMS;
	localparam logic [GEN_W-1:0] GEN_POLY = 20'd404429;

	// Operation codes carried on the func field.
	localparam logic FUNC_ENCODE = 1'b0;
	localparam logic FUNC_DECODE = 1'b1;

	// GF(4) product, indexed by {a, b}; codes 2 and 3 are x and x+1.
	localparam logic [1:0] GF4_MUL [16] = '{
		2'd0, 2'd0, 2'd0, 2'd0,
		2'd0, 2'd1, 2'd2, 2'd3,
		2'd0, 2'd2, 2'd3, 2'd1,
		2'd0, 2'd3, 2'd1, 2'd2
	};

	// The generator scaled by one GF(4) symbol, one product per coefficient.
	function automatic logic [GEN_W-1:0] gen_scaled(input logic [1:0] c);
		logic [GEN_W-1:0] acc;
		acc = '0;
		for (int j = 0; j < GEN_SYMS; j++) begin
			acc[2*j +: 2] = GF4_MUL[{c, GEN_POLY[2*j +: 2]}];
		end
		return acc;
	endfunction

endpackage

FILE: hw/rtl/gf4cc_in_if.sv
// Request channel of the GF(4) cyclic code codec: valid/ready plus payload.
// Depends on gf4cc_pkg for the word width.
interface gf4cc_in_if;
	import gf4cc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 func;
	logic [WORD_BITS-1:0] word_in;

	modport source (output valid, output func, output word_in, input ready);
	modport sink (input valid, input func, input word_in, output ready);
endinterface

FILE: hw/rtl/gf4cc_out_if.sv
// Result channel of the GF(4) cyclic code codec: valid/ready plus payload.
// Depends on gf4cc_pkg for the word width.
interface gf4cc_out_if;
	import gf4cc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] word_out;
	logic                 invalid;

	modport source (output valid, output word_out, output invalid, input ready);
	modport sink (input valid, input word_out, input invalid, output ready);
endinterface

FILE: hw/rtl/gf4_cyclic_code_codec.sv
// GF(4) cyclic code codec: encoder by the fixed generator and rotation-search decoder.
// Depends on gf4cc_pkg, gf4cc_in_if, gf4cc_out_if and the assertion macro header.
//
// Usage:
// The din channel takes one word at a time: func selects encode or decode and
// word_in carries the message or the received codeword. The dout channel
// returns one word per request: the codeword, or the quotient of the first
// rotation that the generator divides, with invalid set (and word_out zero)
// when no rotation divides. cfg_we/cfg_wdata write the symbol count n; it is
// sampled when a request is accepted, and values outside 10..MAX_SYMBOLS are
// clamped into that range.
// All work goes through one generator scale-and-shift unit, one symbol per
// cycle. Encode multiplies the n-9 message symbols by g. Decode runs long
// division on each rotation and tries up to n rotations, stopping at the
// first one that divides. din.ready is high only while no request is in work.
// The result sits in an output register, so a new request is accepted while a
// finished word still waits on dout; if that register is still full when the
// next result is due, the last step holds until dout.ready frees it.
// Reset clears the sequencer and the output valid and sets n to 20.
`include "gf4_cyclic_code_codec_macros.svh"

module gf4_cyclic_code_codec #(
	parameter int MAX_SYMBOLS = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gf4cc_pkg::SYM_CNT_W-1:0] cfg_wdata,
	gf4cc_in_if.sink                      din,
	gf4cc_out_if.source                   dout
);
	import gf4cc_pkg::*;

	localparam int WORD_W = 2 * MAX_SYMBOLS;
	localparam int EXT_W = (WORD_W > WORD_BITS) ? WORD_W : WORD_BITS;
	localparam logic [SYM_CNT_W-1:0] N_MIN = SYM_CNT_W'(MIN_SYMBOLS);
	localparam logic [SYM_CNT_W-1:0] N_MAX = SYM_CNT_W'(MAX_SYMBOLS);
	localparam logic [SYM_CNT_W-1:0] DEG = SYM_CNT_W'(GEN_DEGREE);
	localparam logic [SYM_CNT_W-1:0] ONE = SYM_CNT_W'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ENC,
		ST_DEC
	} state_t;

	state_t                 state_q;
	logic [SYM_CNT_W-1:0]   symbol_count_q;
	logic [SYM_CNT_W-1:0]   n_q;
	logic [SYM_CNT_W-1:0]   cnt_q;
	logic [SYM_CNT_W-1:0]   rot_q;
	logic                   out_valid_q;
	logic [WORD_BITS-1:0]   out_word_q;
	logic                   out_inv_q;
	logic [WORD_W-1:0]      mask_q;
	logic [WORD_W-1:0]      w_q;
	logic [WORD_W-1:0]      rem_q;
	logic [WORD_W-1:0]      quo_q;

	logic [SYM_CNT_W-1:0]   n_eff;
	logic [WORD_W-1:0]      mask_n;
	logic [WORD_W-1:0]      mask_msg;
	logic [EXT_W-1:0]       word_ext;
	logic [WORD_W-1:0]      word_w;
	logic                   accept;
	logic [1:0]             unit_c;
	logic [SYM_CNT_W-1:0]   unit_k;
	logic [WORD_W-1:0]      unit_out;
	logic [WORD_W-1:0]      rem_next;
	logic [WORD_W-1:0]      quo_next;
	logic [WORD_W-1:0]      rem_shr;
	logic [WORD_W-1:0]      w_shr;
	logic [WORD_W-1:0]      w_rot;
	logic                   enc_last;
	logic                   div_last;
	logic                   rem_zero;
	logic                   rot_last;
	logic                   out_free;
	logic                   enc_adv;
	logic                   dec_div;
	logic                   dec_rot;
	logic                   finish;
	logic [WORD_W-1:0]      res_word;
	logic [EXT_W-1:0]       res_ext;
	logic                   res_inv;

	// Symbol count register; the user must write it only while the block is idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_count_q <= SYM_CNT_RESET;
		end else if (cfg_we) begin
			symbol_count_q <= cfg_wdata;
		end
	end

	// Clamp n into the supported range.
	always_comb begin
		priority if (symbol_count_q < N_MIN) begin
			n_eff = N_MIN;
		end else if (symbol_count_q > N_MAX) begin
			n_eff = N_MAX;
		end else begin
			n_eff = symbol_count_q;
		end
	end

	// Masks for a codeword of n symbols and a message of n-9 symbols.
	assign mask_n   = ~({WORD_W{1'b1}} << {n_eff, 1'b0});
	assign mask_msg = ~({WORD_W{1'b1}} << {n_eff - DEG, 1'b0});
	assign word_ext = EXT_W'(din.word_in);
	assign word_w   = word_ext[WORD_W-1:0];

	assign din.ready = (state_q == ST_IDLE);
	assign accept    = din.valid && din.ready;

	// Symbol picks: top remainder symbol at the division index, top word symbol.
	assign rem_shr = rem_q >> {cnt_q, 1'b0};
	assign w_shr   = w_q >> {n_q - ONE, 1'b0};
	assign w_rot   = ((w_q << 2) & mask_q) | WORD_W'(w_shr[1:0]);

	// Operand select for the shared unit: message symbol or leading remainder symbol.
	always_comb begin
		if (state_q == ST_DEC) begin
			unit_c = rem_shr[1:0];
			unit_k = cnt_q - DEG;
		end else begin
			unit_c = w_q[1:0];
			unit_k = cnt_q;
		end
	end

	// Shared unit: c * g * X^k, folded into the accumulator or remainder.
	assign unit_out = WORD_W'(gen_scaled(unit_c)) << {unit_k, 1'b0};
	assign rem_next = rem_q ^ unit_out;
	assign quo_next = quo_q | (WORD_W'(unit_c) << {unit_k, 1'b0});

	// Sequencer conditions.
	assign enc_last = (cnt_q == n_q - N_MIN);
	assign div_last = (cnt_q == DEG);
	assign rem_zero = (rem_next == '0);
	assign rot_last = (rot_q == n_q - ONE);
	assign out_free = !out_valid_q || dout.ready;
	assign enc_adv  = (state_q == ST_ENC) && (!enc_last || out_free);
	assign dec_div  = (state_q == ST_DEC) && !div_last;
	assign dec_rot  = (state_q == ST_DEC) && div_last && !rem_zero && !rot_last;
	assign finish   = out_free && (((state_q == ST_ENC) && enc_last)
		|| ((state_q == ST_DEC) && div_last && (rem_zero || rot_last)));

	// Result word: codeword, quotient on a dividing rotation, else zero.
	always_comb begin
		if (state_q == ST_ENC) begin
			res_word = rem_next;
			res_inv  = 1'b0;
		end else if (rem_zero) begin
			res_word = quo_next;
			res_inv  = 1'b0;
		end else begin
			res_word = '0;
			res_inv  = 1'b1;
		end
	end
	assign res_ext = EXT_W'(res_word);

	// Sequencer state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= SYM_CNT_RESET;
			cnt_q       <= '0;
			rot_q       <= '0;
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
			out_inv_q   <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
				out_word_q  <= res_ext[WORD_BITS-1:0];
				out_inv_q   <= res_inv;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						n_q   <= n_eff;
						rot_q <= '0;
						if (din.func == FUNC_DECODE) begin
							cnt_q   <= n_eff - ONE;
							state_q <= ST_DEC;
						end else begin
							cnt_q   <= '0;
							state_q <= ST_ENC;
						end
					end
				end
				ST_ENC: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end else if (enc_adv) begin
						cnt_q <= cnt_q + ONE;
					end
				end
				ST_DEC: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end else if (dec_div) begin
						cnt_q <= cnt_q - ONE;
					end else if (dec_rot) begin
						cnt_q <= n_q - ONE;
						rot_q <= rot_q + ONE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working words: message shifter or rotated word, remainder, quotient.
	always_ff @(posedge clk) begin
		if (accept) begin
			mask_q <= mask_n;
			quo_q  <= '0;
			if (din.func == FUNC_DECODE) begin
				w_q   <= word_w & mask_n;
				rem_q <= word_w & mask_n;
			end else begin
				w_q   <= word_w & mask_msg;
				rem_q <= '0;
			end
		end else if (enc_adv) begin
			w_q   <= w_q >> 2;
			rem_q <= rem_next;
		end else if (dec_div) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
		end else if (dec_rot) begin
			w_q   <= w_rot;
			rem_q <= w_rot;
			quo_q <= '0;
		end
	end

	assign dout.valid    = out_valid_q;
	assign dout.word_out = out_word_q;
	assign dout.invalid  = out_inv_q;

	// Checks on the sequencer and the result register.
	`GF4CC_ASSERT(a_busy_after_accept, din.valid && din.ready |=> !din.ready, "ready stayed high after a request was taken")
	`GF4CC_ASSERT_IMP(a_rot_in_range, state_q == ST_DEC, rot_q < n_q, "rotation count reached n")
	`GF4CC_ASSERT_IMP(a_invalid_zero, dout.valid && dout.invalid, dout.word_out == '0, "invalid result carries a nonzero word")
	`GF4CC_ASSERT(a_enc_valid, (state_q == ST_ENC) && finish |=> out_valid_q && !out_inv_q, "encode result flagged invalid")

endmodule
